[rtl/linear_gradient_pad_pixel_macros.svh]
// assertion macros for the padded linear gradient pixel unit
// included by the rtl files that carry assertions; no other dependencies
`ifndef LINEAR_GRADIENT_PAD_PIXEL_MACROS_SVH
`define LINEAR_GRADIENT_PAD_PIXEL_MACROS_SVH

`ifndef ASSERT_OFF
`define LGP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LGP_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LGP_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define LGP_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

[rtl/lgp_pkg.sv]
// shared constants and types for the padded linear gradient pixel unit
// used by lgp_table and linear_gradient_pad_pixel; no dependencies
`timescale 1ns / 1ps

package lgp_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = 11;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int COLOR_W     = 32;
  localparam int INDEX_W     = 10;
  localparam int DIR_W       = 18;
  localparam int COORD_W     = 32;
  localparam int WEIGHT_W    = 9;

  localparam logic [COORD_W-1:0] HALF_PIXEL = 32'h0000_8000;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_RENDER = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIR_X        = 3'd0,
    REG_DIR_Y        = 3'd1,
    REG_START_X      = 3'd2,
    REG_START_Y      = 3'd3,
    REG_TABLE_LENGTH = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [COLOR_W-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr_lo;
    logic [ADDR_W-1:0] addr_hi;
  } rd_req_t;

endpackage

[rtl/linear_gradient_pad_pixel.sv]
// an accepted render word passes s1, s2, s3, s4 and the output register before out_valid
// throughput: one word per cycle while out_stall does not back up the pipe, loads and renders alike, limited by the
//   five-stage pipe: offset, multiply, sum, table read, blend into output reg
// reset clears pipeline valids and config registers (table_length to 1);
//   table contents are undefined until loaded, no clearing pass
`timescale 1ns / 1ps
`include "linear_gradient_pad_pixel_macros.svh"

module linear_gradient_pad_pixel (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_command,
  input  logic [lgp_pkg::INDEX_W-1:0]        in_entry_index,
  input  logic [lgp_pkg::COLOR_W-1:0]        in_entry_color,
  input  logic signed [lgp_pkg::COORD_W-1:0] in_x_coord,
  input  logic signed [lgp_pkg::COORD_W-1:0] in_y_coord,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [lgp_pkg::COLOR_W-1:0]        out_pixel_color,
  input  logic                               cfg_we,
  input  logic [lgp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lgp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lgp_pkg::*;

  function automatic logic [COLOR_W-1:0] blend_px(input logic [COLOR_W-1:0] a,
                                                  input logic [COLOR_W-1:0] b,
                                                  input logic [WEIGHT_W-1:0] w);
    logic [16:0]         t;
    logic [WEIGHT_W-1:0] wi;
    logic [COLOR_W-1:0]  res;
    int                  ch;
    wi  = 9'h100 - w;
    res = '0;
    for (ch = 0; ch < 4; ch++) begin
      t = 17'(a[ch*8 +: 8]) * 17'(wi) + 17'(b[ch*8 +: 8]) * 17'(w);
      res[ch*8 +: 8] = t[15:8];
    end
    return res;
  endfunction

  // configuration
  logic signed [DIR_W-1:0]   dir_x_r, dir_y_r;
  logic signed [COORD_W-1:0] start_x_r, start_y_r;
  logic [ADDR_W-1:0]         last_idx_r;
  logic [ADDR_W-1:0]         last_idx_nxt;
  logic [LEN_W-1:0]          cfg_len;

  // pipeline
  logic                      s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic                      adv1, adv2, adv3, adv4, adv5;
  cmd_t                      s1_cmd_r, s2_cmd_r, s3_cmd_r;
  logic [INDEX_W-1:0]        s1_idx_r, s2_idx_r, s3_idx_r;
  logic [COLOR_W-1:0]        s1_color_r, s2_color_r, s3_color_r;
  logic signed [COORD_W-1:0] s1_offx_r, s1_offy_r;
  logic signed [49:0]        prod_x, prod_y;
  logic [COORD_W-1:0]        s2_px_r, s2_py_r;
  logic [COORD_W-1:0]        s3_dist_r;
  logic [WEIGHT_W-1:0]       s4_w_r;
  logic [COLOR_W-1:0]        out_color_r;

  // table read setup
  logic [15:0]               ip;
  logic                      ip_neg, ip_hi, do_blend;
  logic [ADDR_W-1:0]         addr_lo;
  logic [WEIGHT_W-1:0]       w3;
  wr_req_t                   wr;
  rd_req_t                   rd;
  logic [COLOR_W-1:0]        rd_lo_data, rd_hi_data;

  // length clamped to 1..depth, kept as the last usable index
  assign cfg_len = cfg_data[LEN_W-1:0];
  always_comb begin
    priority if (cfg_len == '0) begin
      last_idx_nxt = '0;
    end else if (32'(cfg_len) > TABLE_DEPTH) begin
      last_idx_nxt = ADDR_W'(TABLE_DEPTH - 1);
    end else begin
      last_idx_nxt = ADDR_W'(cfg_len - LEN_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_x_r    <= '0;
      dir_y_r    <= '0;
      start_x_r  <= '0;
      start_y_r  <= '0;
      last_idx_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIR_X:        dir_x_r    <= cfg_data[DIR_W-1:0];
        REG_DIR_Y:        dir_y_r    <= cfg_data[DIR_W-1:0];
        REG_START_X:      start_x_r  <= cfg_data[COORD_W-1:0];
        REG_START_Y:      start_y_r  <= cfg_data[COORD_W-1:0];
        REG_TABLE_LENGTH: last_idx_r <= last_idx_nxt;
        default: ;
      endcase
    end
  end

  // a stage loads when empty or when its content moves on
  assign adv5     = !out_v_r || !out_stall;
  assign adv4     = !s4_v_r || adv5;
  assign adv3     = !s3_v_r || adv4;
  assign adv2     = !s2_v_r || adv3;
  assign adv1     = !s1_v_r || adv2;
  assign in_stall = !adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r  <= in_valid;
      if (adv2) s2_v_r  <= s1_v_r;
      if (adv3) s3_v_r  <= s2_v_r;
      // loads end at the table write
      if (adv4) s4_v_r  <= s3_v_r && (s3_cmd_r == CMD_RENDER);
      if (adv5) out_v_r <= s4_v_r;
    end
  end

  assign prod_x = dir_x_r * s1_offx_r;
  assign prod_y = dir_y_r * s1_offy_r;

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_cmd_r   <= cmd_t'(in_command);
      s1_idx_r   <= in_entry_index;
      s1_color_r <= in_entry_color;
      s1_offx_r  <= in_x_coord - start_x_r + HALF_PIXEL;
      s1_offy_r  <= in_y_coord - start_y_r + HALF_PIXEL;
    end
    if (adv2) begin
      s2_cmd_r   <= s1_cmd_r;
      s2_idx_r   <= s1_idx_r;
      s2_color_r <= s1_color_r;
      s2_px_r    <= prod_x[47:16];
      s2_py_r    <= prod_y[47:16];
    end
    if (adv3) begin
      s3_cmd_r   <= s2_cmd_r;
      s3_idx_r   <= s2_idx_r;
      s3_color_r <= s2_color_r;
      s3_dist_r  <= s2_px_r + s2_py_r - HALF_PIXEL;
    end
    if (adv4) begin
      s4_w_r     <= w3;
    end
    if (adv5) begin
      out_color_r <= blend_px(rd_lo_data, rd_hi_data, s4_w_r);
    end
  end

  // clamped cases read one entry twice with weight zero, which returns it as is
  assign ip       = s3_dist_r[31:16];
  assign ip_neg   = ip[15];
  assign ip_hi    = 32'(ip) >= 32'(last_idx_r);
  assign do_blend = !ip_neg && !ip_hi;

  always_comb begin
    priority if (ip_neg) begin
      addr_lo = '0;
    end else if (ip_hi) begin
      addr_lo = last_idx_r;
    end else begin
      addr_lo = ADDR_W'(ip);
    end
  end

  assign w3 = do_blend ? WEIGHT_W'(s3_dist_r[15:8]) + WEIGHT_W'(1) : '0;

  assign wr.we   = adv4 && s3_v_r && (s3_cmd_r == CMD_LOAD) && (32'(s3_idx_r) < TABLE_DEPTH);
  assign wr.addr = ADDR_W'(s3_idx_r);
  assign wr.data = s3_color_r;

  assign rd.en      = adv4 && s3_v_r && (s3_cmd_r == CMD_RENDER);
  assign rd.addr_lo = addr_lo;
  assign rd.addr_hi = do_blend ? addr_lo + ADDR_W'(1) : addr_lo;

  lgp_table u_table (
    .clk        (clk),
    .wr         (wr),
    .rd         (rd),
    .rd_lo_data (rd_lo_data),
    .rd_hi_data (rd_hi_data)
  );

  assign out_valid       = out_v_r;
  assign out_pixel_color = out_color_r;

  `LGP_ASSERT_NXT(a_load_no_result, clk, rst_n, adv4 && s3_v_r && s3_cmd_r == CMD_LOAD, !s4_v_r)
  `LGP_ASSERT_IMP(a_port_excl, clk, rst_n, wr.we, !rd.en)
  `LGP_ASSERT_IMP(a_addr_pair, clk, rst_n, rd.en && rd.addr_hi != rd.addr_lo, rd.addr_hi == rd.addr_lo + ADDR_W'(1) && rd.addr_hi <= last_idx_r)
  `LGP_ASSERT_NXT(a_clamp_weight, clk, rst_n, rd.en && rd.addr_hi == rd.addr_lo, s4_w_r == '0)

endmodule

[rtl/lgp_table.sv]
// color table: one write port, two registered read ports
// depends on lgp_pkg
`timescale 1ns / 1ps

module lgp_table (
  input  logic                         clk,
  input  lgp_pkg::wr_req_t             wr,
  input  lgp_pkg::rd_req_t             rd,
  output logic [lgp_pkg::COLOR_W-1:0]  rd_lo_data,
  output logic [lgp_pkg::COLOR_W-1:0]  rd_hi_data
);
  import lgp_pkg::*;

  logic [COLOR_W-1:0] mem [TABLE_DEPTH];
  logic [COLOR_W-1:0] rd_lo_r;
  logic [COLOR_W-1:0] rd_hi_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read data holds while the consuming stage is stalled
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_lo_r <= mem[rd.addr_lo];
      rd_hi_r <= mem[rd.addr_hi];
    end
  end

  assign rd_lo_data = rd_lo_r;
  assign rd_hi_data = rd_hi_r;

endmodule
